### rtl/i2da_pkg.sv
// Shared types and constants for the integer to decimal ASCII converter.
package i2da_pkg;

	typedef struct packed {
		logic [31:0] value;
		logic        signed_mode;
	} in_t;

	typedef struct packed {
		logic [6:0] character;
		logic [3:0] position;
		logic       last;
	} out_t;

	typedef enum logic [1:0] {
		CONV_IDLE,
		CONV_RUN,
		CONV_DONE
	} conv_state_t;

	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_MINUS = 7'h2D;

	// Binary bits consumed by the converter per clock while it runs
	localparam int STEP_BITS = 4;

endpackage

### rtl/i2da_front.sv
// Front end: accepts input beats, masks the word and splits sign from magnitude.
module i2da_front #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  i2da_pkg::in_t         in_data,
	output logic                  push_valid,
	input  logic                  push_ready,
	output logic [VALUE_BITS:0]   push_data
);

	logic [VALUE_BITS-1:0] word;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;

	always_comb begin
		word = VALUE_BITS'(in_data.value);
		neg  = in_data.signed_mode & word[VALUE_BITS-1];
		// two's complement negation; the most negative word maps onto its own bit pattern
		mag  = neg ? VALUE_BITS'(~word + 1'b1) : word;
	end

	assign push_valid = in_valid;
	assign in_ready   = push_ready;
	assign push_data  = {neg, mag};

endmodule

### rtl/i2da_queue.sv
// Two-entry queue between the front end and the converter.
module i2da_queue #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/i2da_conv.sv
// Converter: double-dabble binary to BCD, several bits per clock, then finds the leading digit.
module i2da_conv #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 10,
	parameter int IDX_W      = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    q_ready,
	input  logic [VALUE_BITS:0]     q_data,
	output logic                    dig_valid,
	input  logic                    dig_ready,
	output logic [MAX_DIGITS*4-1:0] dig_bcd,
	output logic                    dig_neg,
	output logic [IDX_W-1:0]        dig_top
);

	localparam int STEPS    = (VALUE_BITS + i2da_pkg::STEP_BITS - 1) / i2da_pkg::STEP_BITS;
	localparam int PAD_BITS = STEPS * i2da_pkg::STEP_BITS;
	localparam int BCD_W    = MAX_DIGITS * 4;
	localparam int CNT_W    = $clog2(STEPS);

	i2da_pkg::conv_state_t state_q, state_n;

	logic [PAD_BITS-1:0] bin_q, bin_n;
	logic [BCD_W-1:0]    bcd_q, bcd_n;
	logic                neg_q;
	logic [CNT_W-1:0]    step_q;
	logic                run_en;
	logic                last_step;

	assign last_step = (step_q == CNT_W'(STEPS - 1));

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			i2da_pkg::CONV_IDLE: begin
				if (q_valid) state_n = i2da_pkg::CONV_RUN;
			end
			i2da_pkg::CONV_RUN: begin
				if (last_step) state_n = i2da_pkg::CONV_DONE;
			end
			i2da_pkg::CONV_DONE: begin
				if (dig_ready) state_n = i2da_pkg::CONV_IDLE;
			end
			default: state_n = i2da_pkg::CONV_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_ready   = 1'b0;
		dig_valid = 1'b0;
		run_en    = 1'b0;
		case (state_q)
			i2da_pkg::CONV_IDLE: q_ready   = 1'b1;
			i2da_pkg::CONV_RUN:  run_en    = 1'b1;
			i2da_pkg::CONV_DONE: dig_valid = 1'b1;
			default: ;
		endcase
	end

	// one clock of shift-add-3 over STEP_BITS input bits
	always_comb begin
		bcd_n = bcd_q;
		bin_n = bin_q;
		for (int b = 0; b < i2da_pkg::STEP_BITS; b++) begin
			for (int d = 0; d < MAX_DIGITS; d++) begin
				if (bcd_n[d*4 +: 4] >= 4'd5) begin
					bcd_n[d*4 +: 4] = bcd_n[d*4 +: 4] + 4'd3;
				end
			end
			bcd_n = {bcd_n[BCD_W-2:0], bin_n[PAD_BITS-1]};
			bin_n = {bin_n[PAD_BITS-2:0], 1'b0};
		end
	end

	// highest non-zero digit; zero keeps a single digit
	always_comb begin
		dig_top = '0;
		for (int d = 1; d < MAX_DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) dig_top = IDX_W'(d);
		end
	end

	assign dig_bcd = bcd_q;
	assign dig_neg = neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2da_pkg::CONV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			if (run_en) begin
				step_q <= last_step ? '0 : step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_ready && q_valid) begin
			bin_q <= PAD_BITS'(q_data[VALUE_BITS-1:0]);
			bcd_q <= '0;
			neg_q <= q_data[VALUE_BITS];
		end else if (run_en) begin
			bin_q <= bin_n;
			bcd_q <= bcd_n;
		end
	end

endmodule

### rtl/i2da_emit.sv
// Emitter: walks the digits of one number out, one character per beat, through an output register.
module i2da_emit #(
	parameter int MAX_DIGITS = 10,
	parameter int IDX_W      = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    dig_valid,
	output logic                    dig_ready,
	input  logic [MAX_DIGITS*4-1:0] dig_bcd,
	input  logic                    dig_neg,
	input  logic [IDX_W-1:0]        dig_top,
	output logic                    out_valid,
	input  logic                    out_ready,
	output i2da_pkg::out_t          out_data
);

	logic [MAX_DIGITS*4-1:0] digits_q;
	logic                    busy_q;
	logic                    neg_q;
	logic [IDX_W-1:0]        idx_q;
	logic [3:0]              pos_q;
	logic                    out_valid_q;
	i2da_pkg::out_t          out_q;
	logic                    issue;
	logic                    final_char;
	logic [3:0]              digit;

	assign dig_ready  = !busy_q;
	assign issue      = busy_q && (!out_valid_q || out_ready);
	assign final_char = !neg_q && (idx_q == '0);
	assign digit      = digits_q[idx_q*4 +: 4];
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			neg_q       <= 1'b0;
			idx_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (dig_valid && !busy_q) begin
				busy_q <= 1'b1;
				neg_q  <= dig_neg;
				idx_q  <= dig_top;
				pos_q  <= '0;
			end else if (issue) begin
				pos_q <= pos_q + 1'b1;
				if (neg_q) begin
					neg_q <= 1'b0;
				end else if (final_char) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dig_valid && !busy_q) begin
			digits_q <= dig_bcd;
		end
		if (issue) begin
			out_q.character <= neg_q ? i2da_pkg::CHAR_MINUS
			                         : i2da_pkg::CHAR_ZERO + {3'b000, digit};
			out_q.position  <= pos_q;
			out_q.last      <= final_char;
		end
	end

endmodule

### rtl/integer_to_decimal_ascii.sv
// Converts a VALUE_BITS-bit word, signed or unsigned, into decimal ASCII text, one character
// per output beat, most significant first, with last set on the final character. A front end
// splits sign and magnitude into a two-entry queue; a double-dabble converter takes four bits a
// clock while it runs, and an emitter with its own digit buffer sends the text while the next
// number converts. The emitter takes a new number only once it has sent the last character of
// the previous one.
module integer_to_decimal_ascii #(
	parameter int VALUE_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  i2da_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output i2da_pkg::out_t out_data
);

	localparam int MAX_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int IDX_W      = $clog2(MAX_DIGITS);

	logic                    push_valid;
	logic                    push_ready;
	logic [VALUE_BITS:0]     push_data;
	logic                    q_valid;
	logic                    q_ready;
	logic [VALUE_BITS:0]     q_data;
	logic                    dig_valid;
	logic                    dig_ready;
	logic [MAX_DIGITS*4-1:0] dig_bcd;
	logic                    dig_neg;
	logic [IDX_W-1:0]        dig_top;

	i2da_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	i2da_queue #(
		.W(VALUE_BITS + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_data)
	);

	i2da_conv #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS),
		.IDX_W     (IDX_W)
	) u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data),
		.dig_valid(dig_valid),
		.dig_ready(dig_ready),
		.dig_bcd  (dig_bcd),
		.dig_neg  (dig_neg),
		.dig_top  (dig_top)
	);

	i2da_emit #(
		.MAX_DIGITS(MAX_DIGITS),
		.IDX_W     (IDX_W)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.dig_valid(dig_valid),
		.dig_ready(dig_ready),
		.dig_bcd  (dig_bcd),
		.dig_neg  (dig_neg),
		.dig_top  (dig_top),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
